// ----- hw/rtl/aws_pkg.sv -----
`default_nettype none
package aws_pkg;
    localparam int ImgWidth = 64;
    localparam int ImgHeight = 64;
    localparam int XW = $clog2(ImgWidth);
    localparam int YW = $clog2(ImgHeight);
    localparam int AddrW = XW + YW;
    localparam int BankXW = XW - 1;
    localparam int BankYW = YW - 1;
    localparam int BankAW = BankXW + BankYW;

    typedef enum logic [2:0] {
        REG_M00 = 3'd0, REG_M01 = 3'd1, REG_M02 = 3'd2, REG_M10 = 3'd3,
        REG_M11 = 3'd4, REG_M12 = 3'd5, REG_MODE = 3'd6
    } t_reg_idx;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [5:0] pixel_x;
        logic [5:0] pixel_y;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;
endpackage
`default_nettype wire

// ----- hw/rtl/aws_blend.sv -----
`default_nettype none
module aws_blend
    import aws_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    input  wire logic [7:0] i_p00,
    input  wire logic [7:0] i_p10,
    input  wire logic [7:0] i_p01,
    input  wire logic [7:0] i_p11,
    output logic [7:0]      o_val
);
    // stage 1: blend along x; stage 2: blend along y
    logic [16:0] r_row0;
    logic [16:0] r_row1;
    logic [8:0]  r_b;
    logic [25:0] n_sum;
    logic [8:0]  ia;

    assign ia = 9'd256 - {1'b0, i_a};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row0 <= ({8'd0, ia} * {9'd0, i_p00}) + ({9'd0, i_a} * {9'd0, i_p10});
            r_row1 <= ({8'd0, ia} * {9'd0, i_p01}) + ({9'd0, i_a} * {9'd0, i_p11});
            r_b    <= {1'b0, i_b};
        end
    end

    always_comb begin
        n_sum = ({17'd0, 9'd256 - r_b} * {9'd0, r_row0}) + ({17'd0, r_b} * {9'd0, r_row1});
        o_val = n_sum[23:16];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/affine_warp_sampler.sv -----
// channel | valid        | flow control | payload
// in      | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
// out     | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
// cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_idx, i_cfg_data
// One item per cycle while the output is not stalled; the stages are products, sums/floor/address,
// four-bank RAM read, x blend, then the output register (y blend in front of it).
// Pixels sit in four banks by x/y parity so the four neighbors are read in parallel.
// Reset clears valid flags and loads the identity matrix and bilinear mode; the pixel store is not cleared.
// A stall on the output freezes the whole pipeline.
`default_nettype none
module affine_warp_sampler
    import aws_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    logic signed [31:0] r_m [6];
    logic r_mode;
    logic adv;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0] <= 32'sd65536; r_m[1] <= '0; r_m[2] <= '0;
            r_m[3] <= '0; r_m[4] <= 32'sd65536; r_m[5] <= '0;
            r_mode <= MODE_BILINEAR;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_M00: r_m[0] <= i_cfg_data;
                REG_M01: r_m[1] <= i_cfg_data;
                REG_M02: r_m[2] <= i_cfg_data;
                REG_M10: r_m[3] <= i_cfg_data;
                REG_M11: r_m[4] <= i_cfg_data;
                REG_M12: r_m[5] <= i_cfg_data;
                REG_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline valid bits: s1 products, s2 sums/address, s3 ram, s4 blend, out
    logic r_v1, r_v2, r_v3, r_v4;
    assign adv = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            o_out_valid <= r_v4;
        end
    end

    // stage 1: four products
    logic signed [38:0] r_p [4];
    logic signed [31:0] r_c0, r_c1;
    t_in_item r_it1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= r_m[0] * $signed({1'b0, i_in_data.pixel_x});
            r_p[1] <= r_m[1] * $signed({1'b0, i_in_data.pixel_y});
            r_p[2] <= r_m[3] * $signed({1'b0, i_in_data.pixel_x});
            r_p[3] <= r_m[4] * $signed({1'b0, i_in_data.pixel_y});
            r_c0 <= r_m[2];
            r_c1 <= r_m[5];
            r_it1 <= i_in_data;
        end
    end

    // stage 2: sums, floor, range, neighbors
    logic signed [40:0] xs, ys;
    logic signed [24:0] x0, y0;
    logic oor;
    logic [XW-1:0] n_x0, n_x1, n_nx;
    logic [YW-1:0] n_y0, n_y1, n_ny;
    always_comb begin
        xs = 41'(r_p[0]) + 41'(r_p[1]) + 41'(r_c0);
        ys = 41'(r_p[2]) + 41'(r_p[3]) + 41'(r_c1);
        x0 = xs[40:16];
        y0 = ys[40:16];
        oor = x0 < 0 || x0 >= 25'(ImgWidth) || y0 < 0 || y0 >= 25'(ImgHeight);
        n_x0 = x0[XW-1:0];
        n_y0 = y0[YW-1:0];
        n_x1 = (x0 + 25'sd1 < 25'(ImgWidth)) ? XW'(x0 + 25'sd1) : XW'(ImgWidth - 1);
        n_y1 = (y0 + 25'sd1 < 25'(ImgHeight)) ? YW'(y0 + 25'sd1) : YW'(ImgHeight - 1);
        n_nx = (xs[15:0] > 16'd32768) ? n_x1 : n_x0;
        n_ny = (ys[15:0] > 16'd32768) ? n_y1 : n_y0;
    end

    logic r_req2, r_oor2, r_we2;
    logic [7:0] r_a2, r_b2;
    logic [XW-1:0] r_xa, r_xb;
    logic [YW-1:0] r_ya, r_yb;
    t_rgb r_wd2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req2 <= r_it1.req_type;
            r_oor2 <= oor;
            r_we2 <= r_v1 && r_it1.req_type == REQ_WRITE;
            r_wd2 <= {r_it1.in_red, r_it1.in_green, r_it1.in_blue};
            if (r_it1.req_type == REQ_WRITE) begin
                r_xa <= XW'(r_it1.pixel_x); r_ya <= YW'(r_it1.pixel_y);
                r_xb <= XW'(r_it1.pixel_x); r_yb <= YW'(r_it1.pixel_y);
                r_a2 <= '0; r_b2 <= '0;
            end else if (r_mode == MODE_NEAREST) begin
                r_xa <= n_nx; r_ya <= n_ny; r_xb <= n_nx; r_yb <= n_ny;
                r_a2 <= '0; r_b2 <= '0;
            end else begin
                r_xa <= n_x0; r_ya <= n_y0; r_xb <= n_x1; r_yb <= n_y1;
                r_a2 <= xs[15:8]; r_b2 <= ys[15:8];
            end
        end
    end

    // four banks by (x parity, y parity); 64x64 so every write is in range
    t_rgb r_mem00 [2**BankAW];
    t_rgb r_mem10 [2**BankAW];
    t_rgb r_mem01 [2**BankAW];
    t_rgb r_mem11 [2**BankAW];
    t_rgb bank_rd [4];
    t_rgb r_rd [4];
    logic [BankAW-1:0] ra [4];
    logic [1:0] bsel;
    logic [BankAW-1:0] wa;
    always_comb begin
        // bank k holds x parity k[0], y parity k[1]
        for (int k = 0; k < 4; k++) begin
            ra[k] = {(k[1] == r_ya[0]) ? r_ya[YW-1:1] : r_yb[YW-1:1],
                     (k[0] == r_xa[0]) ? r_xa[XW-1:1] : r_xb[XW-1:1]};
        end
        bsel = {r_ya[0], r_xa[0]};
        wa = {r_ya[YW-1:1], r_xa[XW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_we2 && bsel == 2'd0) r_mem00[wa] <= r_wd2;
            if (r_we2 && bsel == 2'd1) r_mem10[wa] <= r_wd2;
            if (r_we2 && bsel == 2'd2) r_mem01[wa] <= r_wd2;
            if (r_we2 && bsel == 2'd3) r_mem11[wa] <= r_wd2;
            r_rd[0] <= r_mem00[ra[0]];
            r_rd[1] <= r_mem10[ra[1]];
            r_rd[2] <= r_mem01[ra[2]];
            r_rd[3] <= r_mem11[ra[3]];
        end
    end

    // stage 3: route banks to neighbor positions
    logic r_req3, r_oor3;
    logic [7:0] r_a3, r_b3;
    logic [1:0] r_sel3;
    logic r_xe3, r_ye3;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req3 <= r_req2; r_oor3 <= r_oor2;
            r_a3 <= r_a2; r_b3 <= r_b2;
            r_sel3 <= bsel;
            r_xe3 <= r_xa == r_xb;
            r_ye3 <= r_ya == r_yb;
        end
    end

    t_rgb p00, p10, p01, p11;
    always_comb begin
        bank_rd = r_rd;
        p00 = bank_rd[r_sel3];
        p10 = r_xe3 ? p00 : bank_rd[{r_sel3[1], ~r_sel3[0]}];
        p01 = r_ye3 ? p00 : bank_rd[{~r_sel3[1], r_sel3[0]}];
        p11 = r_ye3 ? p10 : (r_xe3 ? p01 : bank_rd[~r_sel3]);
    end

    logic [7:0] bl_r, bl_g, bl_b;
    aws_blend u_r (.i_clk, .i_en(adv), .i_a(r_a3), .i_b(r_b3),
        .i_p00(p00.r), .i_p10(p10.r), .i_p01(p01.r), .i_p11(p11.r), .o_val(bl_r));
    aws_blend u_g (.i_clk, .i_en(adv), .i_a(r_a3), .i_b(r_b3),
        .i_p00(p00.g), .i_p10(p10.g), .i_p01(p01.g), .i_p11(p11.g), .o_val(bl_g));
    aws_blend u_b (.i_clk, .i_en(adv), .i_a(r_a3), .i_b(r_b3),
        .i_p00(p00.b), .i_p10(p10.b), .i_p01(p01.b), .i_p11(p11.b), .o_val(bl_b));

    logic r_req4, r_oor4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req4 <= r_req3; r_oor4 <= r_oor3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_req4 == REQ_WRITE || r_oor4) begin
                o_out_data <= '{8'd0, 8'd0, 8'd0, r_req4 == REQ_SAMPLE};
            end else begin
                o_out_data <= '{bl_b, bl_g, bl_r, 1'b0};
            end
        end
    end

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid) else $error("beat dropped");
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall)) else $error("stall mismatch");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v4 |=> o_out_valid) else $error("pipeline lost beat");
`endif
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import aws_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        o_in_stall, o_out_valid, o_cfg_ready;
    t_out_item   o_out_data;

    affine_warp_sampler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_item    pending_items[$];
    t_out_item   expected_pixels[$];
    logic [23:0] image[ImgWidth*ImgHeight];
    bit          written[ImgWidth*ImgHeight];
    logic signed [31:0] warp_mat[6];
    logic        warp_mode;
    int          errors = 0;
    int          cyc = 0;
    int          n_items = 0;

    // no idling during a long window
    function automatic bit idle_roll();
        if (cyc >= 700 && cyc < 1100) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    function automatic t_out_item warp_pixel(t_in_item it);
        t_out_item r;
        longint xs, ys, x0, y0, x1, y1, nx, ny;
        int unsigned fx, fy, a, b, acc, c;
        logic [23:0] p00, p10, p01, p11, px;
        r = '0;
        if (it.req_type == REQ_WRITE) begin
            image[it.pixel_y * ImgWidth + it.pixel_x] = {it.in_red, it.in_green, it.in_blue};
            return r;
        end
        xs = longint'(warp_mat[0]) * it.pixel_x + longint'(warp_mat[1]) * it.pixel_y
             + longint'(warp_mat[2]);
        ys = longint'(warp_mat[3]) * it.pixel_x + longint'(warp_mat[4]) * it.pixel_y
             + longint'(warp_mat[5]);
        x0 = xs >>> 16;
        y0 = ys >>> 16;
        fx = xs[15:0];
        fy = ys[15:0];
        if (x0 < 0 || x0 >= ImgWidth || y0 < 0 || y0 >= ImgHeight) begin
            r.out_of_range = 1'b1;
            return r;
        end
        x1 = (x0 + 1 < ImgWidth) ? x0 + 1 : ImgWidth - 1;
        y1 = (y0 + 1 < ImgHeight) ? y0 + 1 : ImgHeight - 1;
        if (warp_mode == MODE_NEAREST) begin
            nx = (fx > 32768) ? x1 : x0;
            ny = (fy > 32768) ? y1 : y0;
            px = image[ny * ImgWidth + nx];
        end else begin
            a = fx >> 8;
            b = fy >> 8;
            p00 = image[y0 * ImgWidth + x0];
            p10 = image[y0 * ImgWidth + x1];
            p01 = image[y1 * ImgWidth + x0];
            p11 = image[y1 * ImgWidth + x1];
            for (c = 0; c < 3; c++) begin
                acc = (256 - a) * (256 - b) * ((p00 >> (8*c)) & 8'hff)
                    + a * (256 - b) * ((p10 >> (8*c)) & 8'hff)
                    + (256 - a) * b * ((p01 >> (8*c)) & 8'hff)
                    + a * b * ((p11 >> (8*c)) & 8'hff);
                px[8*c +: 8] = acc[23:16];
            end
        end
        r.out_blue = px[7:0];
        r.out_green = px[15:8];
        r.out_red = px[23:16];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) expected_pixels.push_back(warp_pixel(in_data));
            if (!(in_valid && o_in_stall)) begin
                if (pending_items.size() > 0 && !idle_roll()) begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected output beat");
                    errors++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (o_out_data.out_blue !== e.out_blue) begin
                        $error("out_blue exp %0d got %0d", e.out_blue, o_out_data.out_blue);
                        errors++;
                    end
                    if (o_out_data.out_green !== e.out_green) begin
                        $error("out_green exp %0d got %0d", e.out_green, o_out_data.out_green);
                        errors++;
                    end
                    if (o_out_data.out_red !== e.out_red) begin
                        $error("out_red exp %0d got %0d", e.out_red, o_out_data.out_red);
                        errors++;
                    end
                    if (o_out_data.out_of_range !== e.out_of_range) begin
                        $error("out_of_range exp %0d got %0d", e.out_of_range,
                               o_out_data.out_of_range);
                        errors++;
                    end
                end
            end
            out_stall <= idle_roll();
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_MODE) warp_mode = value[0];
        else warp_mat[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_warp(logic [31:0] a00, logic [31:0] a01, logic [31:0] a02,
                            logic [31:0] a10, logic [31:0] a11, logic [31:0] a12,
                            logic mode);
        write_reg(REG_M00, a00);
        write_reg(REG_M01, a01);
        write_reg(REG_M02, a02);
        write_reg(REG_M10, a10);
        write_reg(REG_M11, a11);
        write_reg(REG_M12, a12);
        write_reg(REG_MODE, {31'd0, mode});
    endtask

    task automatic push_item(logic rt, int x, int y, logic [23:0] rgb);
        t_in_item it;
        it.req_type = rt;
        it.pixel_x = 6'(x);
        it.pixel_y = 6'(y);
        it.in_red = rgb[23:16];
        it.in_green = rgb[15:8];
        it.in_blue = rgb[7:0];
        if (rt == REQ_WRITE) written[y * ImgWidth + x] = 1'b1;
        n_items++;
        pending_items.push_back(it);
    endtask

    task automatic ensure_px(longint x, longint y);
        if (!written[y * ImgWidth + x]) push_item(REQ_WRITE, int'(x), int'(y), 24'($urandom));
    endtask

    // write any not yet written pixel that the sample will read before queuing it
    task automatic push_sample(int x, int y);
        longint xs, ys, x0, y0, x1, y1;
        int unsigned fx, fy;
        xs = longint'(warp_mat[0]) * x + longint'(warp_mat[1]) * y + longint'(warp_mat[2]);
        ys = longint'(warp_mat[3]) * x + longint'(warp_mat[4]) * y + longint'(warp_mat[5]);
        x0 = xs >>> 16;
        y0 = ys >>> 16;
        fx = xs[15:0];
        fy = ys[15:0];
        if (!(x0 < 0 || x0 >= ImgWidth || y0 < 0 || y0 >= ImgHeight)) begin
            x1 = (x0 + 1 < ImgWidth) ? x0 + 1 : ImgWidth - 1;
            y1 = (y0 + 1 < ImgHeight) ? y0 + 1 : ImgHeight - 1;
            if (warp_mode == MODE_NEAREST) begin
                ensure_px((fx > 32768) ? x1 : x0, (fy > 32768) ? y1 : y0);
            end else begin
                ensure_px(x0, y0);
                ensure_px(x1, y0);
                ensure_px(x0, y1);
                ensure_px(x1, y1);
            end
        end
        push_item(REQ_SAMPLE, x, y, 24'h0);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_random(int n);
        int goal;
        goal = n_items + n;
        while (n_items < goal) begin
            if ($urandom_range(0, 99) < 80)
                push_sample($urandom_range(0, 63), $urandom_range(0, 63));
            else
                push_item(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                          24'($urandom));
        end
    endtask

    initial begin
        logic [31:0] r00, r01, r11, r10;
        warp_mat = '{32'sd65536, 0, 0, 0, 32'sd65536, 0};
        warp_mode = MODE_BILINEAR;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(REQ_WRITE, 0, 0, 24'h000000);
        push_item(REQ_WRITE, 63, 63, 24'hffffff);
        push_sample(0, 0);
        push_sample(63, 63);
        push_sample(31, 17);
        drain();

        // exact half: tie goes to lower
        set_warp(32'd65536, 0, 32'd32768, 0, 32'd65536, 32'd32768, MODE_NEAREST);
        push_sample(0, 0);
        push_sample(10, 10);
        push_sample(63, 63);
        drain();
        // just over half in x (exact half in y), edge clamp
        set_warp(32'd65536, 0, 32'd32769, 0, 32'd65536, 32'd98304, MODE_NEAREST);
        push_sample(63, 62);
        push_sample(63, 63);
        push_sample(5, 9);
        drain();
        write_reg(REG_MODE, {31'd0, MODE_BILINEAR});
        push_sample(63, 62);
        push_sample(63, 63);
        push_sample(5, 9);
        drain();
        // extreme coefficients
        set_warp(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, MODE_NEAREST);
        push_sample(63, 63);
        push_sample(0, 0);
        drain();
        set_warp(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, MODE_BILINEAR);
        push_sample(63, 63);
        push_sample(0, 0);
        drain();
        set_warp(0, 0, 0, 0, 0, 0, MODE_NEAREST);
        push_sample(63, 63);
        push_item(REQ_WRITE, 0, 0, 24'hffffff);
        push_sample(1, 2);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            r00 = $urandom_range(32768, 98304);
            r11 = $urandom_range(32768, 98304);
            r01 = $urandom_range(0, 32768) - 16384;
            r10 = $urandom_range(0, 32768) - 16384;
            if (ph % 4 == 3) begin
                r00 = -r00;
                r10 = $urandom;
            end
            set_warp(r00, r01, $urandom_range(0, 72 * 65536) - 8 * 65536,
                     r10, r11, $urandom_range(0, 72 * 65536) - 8 * 65536,
                     $urandom_range(0, 1));
            push_random(72);
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/aws_pkg.sv
hw/rtl/aws_blend.sv
hw/rtl/affine_warp_sampler.sv
sim/testbench.sv
